FILE: rtl/core/acbs_pkg.sv
package acbs_pkg;

   localparam int ACBS_MAX_STATES = 1024;
   localparam int ACBS_ALPHABET_SIZE = 256;
   localparam int ACBS_MAX_PATTERNS = 32;

   localparam int STATE_W = 10;
   localparam int BYTE_W = 8;
   localparam int MASK_FIELD_W = 32;
   localparam int OP_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_SCAN = 2'd0;
   localparam logic [OP_W-1:0] OP_GOTO = 2'd1;
   localparam logic [OP_W-1:0] OP_FAIL = 2'd2;
   localparam logic [OP_W-1:0] OP_MASK = 2'd3;

   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] CMD_SCAN = 3'd0;
   localparam logic [KIND_W-1:0] CMD_ROOT = 3'd1;
   localparam logic [KIND_W-1:0] CMD_GOTO = 3'd2;
   localparam logic [KIND_W-1:0] CMD_FAIL = 3'd3;
   localparam logic [KIND_W-1:0] CMD_MASK = 3'd4;

   // ch carries the scanned byte or the goto entry byte
   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [BYTE_W-1:0]       ch;
      logic                    pend;
      logic [STATE_W-1:0]      st;
      logic                    def;
      logic [STATE_W-1:0]      val;
      logic [MASK_FIELD_W-1:0] mask;
   } cmd_type;

endpackage

FILE: rtl/core/acbs_if.sv
interface acbs_req_if;
   import acbs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic [BYTE_W-1:0]       payload_byte;
   logic                    packet_end;
   logic [STATE_W-1:0]      entry_state;
   logic [BYTE_W-1:0]       entry_char;
   logic                    entry_defined;
   logic [STATE_W-1:0]      entry_value;
   logic [MASK_FIELD_W-1:0] entry_mask;

   modport source (
      output valid, op, payload_byte, packet_end, entry_state, entry_char,
             entry_defined, entry_value, entry_mask,
      input  ready
   );
   modport sink (
      input  valid, op, payload_byte, packet_end, entry_state, entry_char,
             entry_defined, entry_value, entry_mask,
      output ready
   );
endinterface

interface acbs_rsp_if;
   import acbs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [STATE_W-1:0]      state_after;
   logic [MASK_FIELD_W-1:0] match_mask;
   logic                    any_match;
   logic                    last_in_packet;

   modport source (
      output valid, state_after, match_mask, any_match, last_in_packet,
      input  ready
   );
   modport sink (
      input  valid, state_after, match_mask, any_match, last_in_packet,
      output ready
   );
endinterface

FILE: rtl/core/aho_corasick_byte_scanner.sv
// aho-corasick multi-pattern byte scanner
// req_ch carries requests: op scan byte, or a write of a goto entry, a failure
// link or a match mask. table writes produce no result; a scan produces one
// result on rsp_ch with the reached state, its match mask, any_match and an
// echo of packet_end. after a scan with packet_end the state returns to root.
// requests pass a classify stage and a two-entry command queue, then the walker.
// the walker visits the registered reads of the goto, failure and mask memories
// in turn, following failure links until an edge or the root is reached; a
// table write is done from idle without a walk. worst case hops are MAX_STATES.
// reset returns the automaton to the root and empties the queue; the tables
// are not cleared and must be written before use.
// when the receiver stalls, the result holds in the output register, the walker
// waits on it, and the queue and front stage fill before req_ch ready drops.
module aho_corasick_byte_scanner
   import acbs_pkg::*;
#(
   parameter int MAX_STATES = ACBS_MAX_STATES,
   parameter int ALPHABET_SIZE = ACBS_ALPHABET_SIZE,
   parameter int MAX_PATTERNS = ACBS_MAX_PATTERNS
) (
   input  logic        clock,
   input  logic        reset,
   acbs_req_if.sink    req_ch,
   acbs_rsp_if.source  rsp_ch
);

   logic    front_valid, queue_full, queue_valid, queue_pop;
   cmd_type front_cmd, queue_cmd;

   acbs_front #(
      .MAX_STATES    (MAX_STATES),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_full  (queue_full)
   );

   acbs_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_cmd   (front_cmd),
      .full       (queue_full),
      .pop_valid  (queue_valid),
      .pop_cmd    (queue_cmd),
      .pop        (queue_pop)
   );

   acbs_back #(
      .MAX_STATES    (MAX_STATES),
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .MAX_PATTERNS  (MAX_PATTERNS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd),
      .cmd_pop   (queue_pop),
      .rsp       (rsp_ch)
   );

endmodule

FILE: rtl/core/acbs_front.sv
module acbs_front
   import acbs_pkg::*;
#(
   parameter int MAX_STATES = ACBS_MAX_STATES,
   parameter int ALPHABET_SIZE = ACBS_ALPHABET_SIZE
) (
   input  logic        clock,
   input  logic        reset,
   acbs_req_if.sink    req,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_full
);

   logic    cmd_valid_ff, cmd_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept, push, keep;
   logic    st_ok, val_ok, ch_ok, byte_ok;

   assign push = cmd_valid_ff && !cmd_full;
   assign req.ready = !cmd_valid_ff || !cmd_full;
   assign accept = req.valid && req.ready;

   assign st_ok = 32'(req.entry_state) < 32'(MAX_STATES);
   assign val_ok = 32'(req.entry_value) < 32'(MAX_STATES);
   assign ch_ok = 32'(req.entry_char) < 32'(ALPHABET_SIZE);
   assign byte_ok = 32'(req.payload_byte) < 32'(ALPHABET_SIZE);

   // classify, clamp out-of-range targets to the root, drop ignored writes
   always_comb begin
      cmd_in = cmd_ff;
      keep = 1'b0;
      if (accept) begin
         cmd_in.pend = req.packet_end;
         cmd_in.st = req.entry_state;
         cmd_in.def = req.entry_defined;
         cmd_in.val = val_ok ? req.entry_value : '0;
         cmd_in.mask = req.entry_mask;
         cmd_in.ch = req.entry_char;
         cmd_in.kind = CMD_SCAN;
         case (req.op)
            OP_SCAN: begin
               cmd_in.ch = req.payload_byte;
               cmd_in.kind = byte_ok ? CMD_SCAN : CMD_ROOT;
               keep = 1'b1;
            end
            OP_GOTO: begin
               cmd_in.kind = CMD_GOTO;
               keep = st_ok && ch_ok;
            end
            OP_FAIL: begin
               cmd_in.kind = CMD_FAIL;
               keep = st_ok;
            end
            OP_MASK: begin
               cmd_in.kind = CMD_MASK;
               keep = st_ok;
            end
            default: begin
               keep = 1'b0;
            end
         endcase
      end
   end

   assign cmd_valid_in = accept ? keep : (cmd_valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd = cmd_ff;

endmodule

FILE: rtl/core/acbs_cmd_fifo.sv
module acbs_cmd_fifo
   import acbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= QUEUE_DEPTH)
      else $error("command queue over capacity");
   a_pop_moves_ptr: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("command queue count lost a pop");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (full && !do_pop) |=> (wr_ptr_ff == $past(wr_ptr_ff)))
      else $error("command queue written while full");

endmodule

FILE: rtl/core/acbs_back.sv
module acbs_back
   import acbs_pkg::*;
#(
   parameter int MAX_STATES = ACBS_MAX_STATES,
   parameter int ALPHABET_SIZE = ACBS_ALPHABET_SIZE,
   parameter int MAX_PATTERNS = ACBS_MAX_PATTERNS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   acbs_rsp_if.source  rsp
);

   localparam int STATES_USED = (MAX_STATES < (1 << STATE_W)) ? MAX_STATES : (1 << STATE_W);
   localparam int SIDX_W = $clog2(STATES_USED);
   localparam int CH_W = $clog2(ALPHABET_SIZE);
   localparam int MASK_W = (MAX_PATTERNS < MASK_FIELD_W) ? MAX_PATTERNS : MASK_FIELD_W;
   localparam int GOTO_DEPTH = STATES_USED * (1 << CH_W);
   localparam int GADDR_W = SIDX_W + CH_W;
   localparam int HOP_W = $clog2(MAX_STATES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_GOTO = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;
   localparam logic [1:0] ST_MASK = 2'd3;

   logic [SIDX_W:0]   goto_mem [GOTO_DEPTH];
   logic [SIDX_W-1:0] fail_mem [STATES_USED];
   logic [MASK_W-1:0] mask_mem [STATES_USED];

   logic [SIDX_W:0]   goto_rd_ff;
   logic [SIDX_W-1:0] fail_rd_ff;
   logic [MASK_W-1:0] mask_rd_ff;

   logic [1:0]        state_ff, state_in;
   logic [SIDX_W-1:0] cur_state_ff, cur_state_in;
   logic [SIDX_W-1:0] walk_ff, walk_in;
   logic [CH_W-1:0]   byte_ff, byte_in;
   logic              pend_ff, pend_in;
   logic [HOP_W-1:0]  hops_ff, hops_in;
   logic [SIDX_W-1:0] ns_ff, ns_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0]      rsp_state_ff;
   logic [MASK_FIELD_W-1:0] rsp_mask_ff;
   logic                    rsp_any_ff;
   logic                    rsp_last_ff;

   logic              goto_we, fail_we, mask_we;
   logic              goto_re, fail_re, mask_re;
   logic [GADDR_W-1:0] goto_waddr, goto_raddr;
   logic [SIDX_W-1:0] fail_raddr, mask_raddr, cmd_st;
   logic              out_load;
   logic              g_def;
   logic [SIDX_W-1:0] g_next;

   assign cmd_st = cmd.st[SIDX_W-1:0];
   assign g_def = goto_rd_ff[SIDX_W];
   assign g_next = goto_rd_ff[SIDX_W-1:0];
   assign goto_waddr = {cmd_st, cmd.ch[CH_W-1:0]};

   always_comb begin
      state_in = state_ff;
      cur_state_in = cur_state_ff;
      walk_in = walk_ff;
      byte_in = byte_ff;
      pend_in = pend_ff;
      hops_in = hops_ff;
      ns_in = ns_ff;
      cmd_pop = 1'b0;
      goto_we = 1'b0;
      fail_we = 1'b0;
      mask_we = 1'b0;
      goto_re = 1'b0;
      fail_re = 1'b0;
      mask_re = 1'b0;
      goto_raddr = {cur_state_ff, cmd.ch[CH_W-1:0]};
      fail_raddr = walk_ff;
      mask_raddr = '0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_SCAN: begin
                     goto_re = 1'b1;
                     walk_in = cur_state_ff;
                     byte_in = cmd.ch[CH_W-1:0];
                     pend_in = cmd.pend;
                     hops_in = '0;
                     state_in = ST_GOTO;
                  end
                  CMD_ROOT: begin
                     mask_re = 1'b1;
                     ns_in = '0;
                     pend_in = cmd.pend;
                     state_in = ST_MASK;
                  end
                  CMD_GOTO: goto_we = 1'b1;
                  CMD_FAIL: fail_we = 1'b1;
                  CMD_MASK: mask_we = 1'b1;
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_GOTO: begin
            if (g_def) begin
               ns_in = g_next;
               mask_re = 1'b1;
               mask_raddr = g_next;
               state_in = ST_MASK;
            end else if (walk_ff == '0 || hops_ff >= HOP_W'(MAX_STATES)) begin
               ns_in = '0;
               mask_re = 1'b1;
               state_in = ST_MASK;
            end else begin
               fail_re = 1'b1;
               state_in = ST_FAIL;
            end
         end
         ST_FAIL: begin
            walk_in = fail_rd_ff;
            hops_in = hops_ff + HOP_W'(1);
            goto_re = 1'b1;
            goto_raddr = {fail_rd_ff, byte_ff};
            state_in = ST_GOTO;
         end
         ST_MASK: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_load = 1'b1;
               cur_state_in = pend_ff ? '0 : ns_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_state_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_state_ff <= cur_state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      byte_ff <= byte_in;
      pend_ff <= pend_in;
      hops_ff <= hops_in;
      ns_ff <= ns_in;
      if (out_load) begin
         rsp_state_ff <= STATE_W'(ns_ff);
         rsp_mask_ff <= MASK_FIELD_W'(mask_rd_ff);
         rsp_any_ff <= mask_rd_ff != '0;
         rsp_last_ff <= pend_ff;
      end
   end

   // goto table
   always_ff @(posedge clock) begin
      if (goto_we) begin
         goto_mem[goto_waddr] <= {cmd.def, cmd.val[SIDX_W-1:0]};
      end
      if (goto_re) begin
         goto_rd_ff <= goto_mem[goto_raddr];
      end
   end

   // failure links
   always_ff @(posedge clock) begin
      if (fail_we) begin
         fail_mem[cmd_st] <= cmd.val[SIDX_W-1:0];
      end
      if (fail_re) begin
         fail_rd_ff <= fail_mem[fail_raddr];
      end
   end

   // match masks
   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[cmd_st] <= cmd.mask[MASK_W-1:0];
      end
      if (mask_re) begin
         mask_rd_ff <= mask_mem[mask_raddr];
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.state_after = rsp_state_ff;
   assign rsp.match_mask = rsp_mask_ff;
   assign rsp.any_match = rsp_any_ff;
   assign rsp.last_in_packet = rsp_last_ff;

   a_hop_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GOTO || state_ff == ST_FAIL) |-> (32'(hops_ff) <= MAX_STATES))
      else $error("failure walk exceeded its hop limit");
   a_packet_root: assert property (@(posedge clock) disable iff (reset)
      (out_load && pend_ff) |=> (cur_state_ff == '0))
      else $error("state did not return to root after packet end");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MASK && rsp_valid_ff && !rsp.ready) |=> (state_ff == ST_MASK))
      else $error("result dropped while receiver stalled");
   a_pop_idle_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !(goto_we || fail_we || mask_we))
      else $error("table written during a scan");

endmodule

FILE: tb/acbs_scan_checker.sv
`timescale 1ns / 100ps

module acbs_scan_checker
   import acbs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   acbs_req_if  req_ch,
   acbs_rsp_if  rsp_ch,
   output int   error_count,
   output int   pending
);

   localparam logic [MASK_FIELD_W-1:0] PATTERN_KEEP =
      (ACBS_MAX_PATTERNS >= MASK_FIELD_W) ? '1 :
      MASK_FIELD_W'((64'd1 << ACBS_MAX_PATTERNS) - 64'd1);

   typedef struct packed {
      logic [STATE_W-1:0]      state_after;
      logic [MASK_FIELD_W-1:0] match_mask;
      logic                    any_match;
      logic                    last_in_packet;
   } scan_result_type;

   // goto entry: {defined, next state}
   logic [STATE_W:0]        goto_entries [logic [STATE_W+BYTE_W-1:0]];
   logic [STATE_W-1:0]      fail_links [ACBS_MAX_STATES];
   logic [MASK_FIELD_W-1:0] state_masks [ACBS_MAX_STATES];
   logic [STATE_W-1:0]      walk_state;
   scan_result_type         due_results [$];

   initial begin
      error_count = 0;
      pending = 0;
      walk_state = '0;
   end

   function automatic logic [STATE_W:0] goto_read(input logic [STATE_W-1:0] st,
                                                  input logic [BYTE_W-1:0] ch);
      logic [STATE_W+BYTE_W-1:0] key;
      key = {st, ch};
      if (goto_entries.exists(key))
         return goto_entries[key];
      return '0;
   endfunction

   // follow failure links until an edge exists for ch, the root or the hop limit
   function automatic logic [STATE_W-1:0] advance(input logic [STATE_W-1:0] from,
                                                  input logic [BYTE_W-1:0] ch);
      logic [STATE_W-1:0] st;
      logic [STATE_W-1:0] nxt;
      logic [STATE_W:0]   entry;
      int                 hops;
      bit                 found;
      st = from;
      nxt = '0;
      hops = 0;
      found = 1'b0;
      while (!found) begin
         entry = goto_read(st, ch);
         if (entry[STATE_W]) begin
            nxt = entry[STATE_W-1:0];
            found = 1'b1;
         end else if (st == '0 || hops >= ACBS_MAX_STATES) begin
            found = 1'b1;
         end else begin
            st = fail_links[st];
            hops++;
         end
      end
      return nxt;
   endfunction

   task automatic absorb_request();
      scan_result_type    want;
      logic [STATE_W-1:0] reached;
      case (req_ch.op)
         OP_SCAN: begin
            reached = advance(walk_state, req_ch.payload_byte);
            want.state_after = reached;
            want.match_mask = state_masks[reached];
            want.any_match = (state_masks[reached] != '0);
            want.last_in_packet = req_ch.packet_end;
            due_results.insert(due_results.size(), want);
            walk_state = req_ch.packet_end ? '0 : reached;
         end
         OP_GOTO: begin
            goto_entries[{req_ch.entry_state, req_ch.entry_char}] =
               {req_ch.entry_defined, req_ch.entry_value};
         end
         OP_FAIL: begin
            fail_links[req_ch.entry_state] = req_ch.entry_value;
         end
         OP_MASK: begin
            state_masks[req_ch.entry_state] = req_ch.entry_mask & PATTERN_KEEP;
         end
         default: ;
      endcase
   endtask

   task automatic check_result();
      scan_result_type want;
      if (due_results.size() == 0) begin
         $error("unexpected result: state_after %0d match_mask %h",
                rsp_ch.state_after, rsp_ch.match_mask);
         error_count++;
      end else begin
         want = due_results.pop_front();
         if (rsp_ch.state_after !== want.state_after) begin
            $error("state_after: expected %0d, actual %0d",
                   want.state_after, rsp_ch.state_after);
            error_count++;
         end
         if (rsp_ch.match_mask !== want.match_mask) begin
            $error("match_mask: expected %h, actual %h",
                   want.match_mask, rsp_ch.match_mask);
            error_count++;
         end
         if (rsp_ch.any_match !== want.any_match) begin
            $error("any_match: expected %b, actual %b",
                   want.any_match, rsp_ch.any_match);
            error_count++;
         end
         if (rsp_ch.last_in_packet !== want.last_in_packet) begin
            $error("last_in_packet: expected %b, actual %b",
                   want.last_in_packet, rsp_ch.last_in_packet);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         walk_state = '0;
         due_results.delete();
      end else begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            absorb_request();
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_result();
      end
      pending = due_results.size();
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb
   import acbs_pkg::*;
;

   localparam int ITEM_TARGET = 1350;
   localparam int HOLD_CYCLES = 300;

   logic clock;
   logic reset;

   acbs_req_if req_ch ();
   acbs_rsp_if rsp_ch ();

   int error_count;
   int pending;

   int sent_count = 0;
   int stall_left = 0;
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;
   bit hold_request = 1'b0;

   logic [STATE_W-1:0] phase_states [$];
   logic [BYTE_W-1:0]  phase_bytes [$];
   bit                 state_taken [ACBS_MAX_STATES];
   bit                 byte_taken [ACBS_ALPHABET_SIZE];

   aho_corasick_byte_scanner i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   acbs_scan_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .error_count (error_count),
      .pending     (pending)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #10_000_000;
      $display("tb: done, errors");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [MASK_FIELD_W-1:0] pick_mask();
      int r;
      r = $urandom_range(99);
      if (r < 35)
         return '0;
      if (r < 45)
         return '1;
      return MASK_FIELD_W'($urandom);
   endfunction

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            stall_left = HOLD_CYCLES - 1;
         end else if (!recv_calm && $urandom_range(99) < 30) begin
            rsp_ch.ready <= 1'b0;
            stall_left = pick_gap();
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic [OP_W-1:0]         code,
                               input logic [BYTE_W-1:0]       data_byte,
                               input logic                    pend,
                               input logic [STATE_W-1:0]      st,
                               input logic [BYTE_W-1:0]       ch,
                               input logic                    def,
                               input logic [STATE_W-1:0]      val,
                               input logic [MASK_FIELD_W-1:0] mask);
      int gap;
      gap = send_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= code;
      req_ch.payload_byte <= data_byte;
      req_ch.packet_end <= pend;
      req_ch.entry_state <= st;
      req_ch.entry_char <= ch;
      req_ch.entry_defined <= def;
      req_ch.entry_value <= val;
      req_ch.entry_mask <= mask;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      sent_count++;
   endtask

   // unused fields of every request carry random noise
   task automatic scan_byte(input logic [BYTE_W-1:0] data_byte, input logic pend);
      send_request(OP_SCAN, data_byte, pend, STATE_W'($urandom), BYTE_W'($urandom),
                   1'($urandom), STATE_W'($urandom), MASK_FIELD_W'($urandom));
   endtask

   task automatic write_goto(input logic [STATE_W-1:0] st, input logic [BYTE_W-1:0] ch,
                             input logic def, input logic [STATE_W-1:0] val);
      send_request(OP_GOTO, BYTE_W'($urandom), 1'($urandom), st, ch, def, val,
                   MASK_FIELD_W'($urandom));
   endtask

   task automatic write_fail(input logic [STATE_W-1:0] st, input logic [STATE_W-1:0] val);
      send_request(OP_FAIL, BYTE_W'($urandom), 1'($urandom), st, BYTE_W'($urandom),
                   1'($urandom), val, MASK_FIELD_W'($urandom));
   endtask

   task automatic write_mask(input logic [STATE_W-1:0] st,
                             input logic [MASK_FIELD_W-1:0] mask);
      send_request(OP_MASK, BYTE_W'($urandom), 1'($urandom), st, BYTE_W'($urandom),
                   1'($urandom), STATE_W'($urandom), mask);
   endtask

   // random automaton over a small byte set; failure links point to earlier
   // states so every chain ends at the root
   task automatic run_phase(input int n_states, input int n_bytes, input int n_scans,
                            input bit squeeze);
      logic [STATE_W-1:0] cand_state;
      logic [BYTE_W-1:0]  cand_byte;
      int                 tgt;
      int                 pos;
      bit                 def;
      phase_states.delete();
      phase_bytes.delete();
      foreach (state_taken[i]) state_taken[i] = 1'b0;
      foreach (byte_taken[i]) byte_taken[i] = 1'b0;
      phase_states.insert(phase_states.size(), STATE_W'(0));
      state_taken[0] = 1'b1;
      while (phase_states.size() < n_states) begin
         cand_state = STATE_W'($urandom_range(ACBS_MAX_STATES - 1, 1));
         if (!state_taken[cand_state]) begin
            state_taken[cand_state] = 1'b1;
            phase_states.insert(phase_states.size(), cand_state);
         end
      end
      while (phase_bytes.size() < n_bytes) begin
         cand_byte = BYTE_W'($urandom);
         if (!byte_taken[cand_byte]) begin
            byte_taken[cand_byte] = 1'b1;
            phase_bytes.insert(phase_bytes.size(), cand_byte);
         end
      end

      for (int i = 0; i < n_states; i++) begin
         foreach (phase_bytes[j]) begin
            if (i + 1 < n_states && $urandom_range(99) < 70)
               tgt = $urandom_range(n_states - 1, i + 1);
            else
               tgt = $urandom_range(n_states - 1);
            def = ($urandom_range(99) < 55);
            write_goto(phase_states[i], phase_bytes[j], def,
                       def ? phase_states[tgt] : STATE_W'($urandom));
         end
         if (i > 0)
            write_fail(phase_states[i], phase_states[$urandom_range(i - 1)]);
         write_mask(phase_states[i], pick_mask());
      end

      if (squeeze)
         hold_request = 1'b1;
      for (int s = 0; s < n_scans; s++) begin
         // table rewrites between scans, keeping the tables complete
         if ($urandom_range(99) < 8) begin
            case ($urandom_range(2))
               0: begin
                  def = ($urandom_range(1) == 1);
                  write_goto(phase_states[$urandom_range(n_states - 1)],
                             phase_bytes[$urandom_range(n_bytes - 1)], def,
                             def ? phase_states[$urandom_range(n_states - 1)]
                                 : STATE_W'($urandom));
               end
               1: begin
                  pos = $urandom_range(n_states - 1, 1);
                  write_fail(phase_states[pos], phase_states[$urandom_range(pos - 1)]);
               end
               default: begin
                  write_mask(phase_states[$urandom_range(n_states - 1)], pick_mask());
               end
            endcase
         end
         scan_byte(phase_bytes[$urandom_range(n_bytes - 1)],
                   (s == n_scans - 1) || ($urandom_range(11) == 0));
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_SCAN;
      req_ch.payload_byte <= '0;
      req_ch.packet_end <= 1'b0;
      req_ch.entry_state <= '0;
      req_ch.entry_char <= '0;
      req_ch.entry_defined <= 1'b0;
      req_ch.entry_value <= '0;
      req_ch.entry_mask <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: root without edge, failure hop to root, failure cycle,
      // extreme indexes and masks, packet end on scans
      write_mask(10'd0, 32'h0000_0000);
      write_mask(10'h3FF, 32'hFFFF_FFFF);
      write_mask(10'h2AA, 32'h8000_0001);
      write_goto(10'd0, 8'h00, 1'b1, 10'h3FF);
      write_goto(10'd0, 8'hFF, 1'b0, 10'h3FF);
      write_goto(10'h3FF, 8'h00, 1'b1, 10'h2AA);
      write_goto(10'h3FF, 8'hFF, 1'b0, 10'd0);
      write_goto(10'h2AA, 8'h00, 1'b1, 10'h3FF);
      write_goto(10'h2AA, 8'hFF, 1'b0, 10'h155);
      write_fail(10'h3FF, 10'h2AA);
      write_fail(10'h2AA, 10'h3FF);
      scan_byte(8'hFF, 1'b0);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'hFF, 1'b0);
      scan_byte(8'h00, 1'b0);
      write_fail(10'h2AA, 10'd0);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'hFF, 1'b0);
      scan_byte(8'h00, 1'b1);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'hFF, 1'b1);

      for (int p = 0; sent_count < ITEM_TARGET; p++) begin
         send_calm = (p == 1) || ($urandom_range(4) == 0);
         recv_calm = (p != 1) && ($urandom_range(4) == 0);
         run_phase(($urandom_range(5) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 2),
                   $urandom_range(6, 2), $urandom_range(130, 50), p == 1);
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/acbs_pkg.sv
rtl/core/acbs_if.sv
rtl/core/acbs_front.sv
rtl/core/acbs_cmd_fifo.sv
rtl/core/acbs_back.sv
rtl/core/aho_corasick_byte_scanner.sv
tb/acbs_scan_checker.sv
tb/tb.sv
